// ===== rtl/core/bfdh_pkg.sv =====
// shared constants for the bloom filter double hash unit
package bfdh_pkg;

   localparam int unsigned FILTER_BITS_DEFAULT = 65536;
   localparam int unsigned MAX_PROBES_DEFAULT  = 16;

   localparam logic [63:0] SEED_A = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MUL_C1 = 64'h87c37b91114253d5;
   localparam logic [63:0] MUL_C2 = 64'h4cf5ad432745937f;
   localparam logic [63:0] ADD_N  = 64'h0000000052dce729;
   localparam logic [63:0] FMIX_1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_2 = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] SEED_M = 64'hc6a4a7935bd1e995;

   localparam logic [1:0] KIND_INSERT  = 2'd0;
   localparam logic [1:0] KIND_QUERY   = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic CSR_BIT_COUNT  = 1'b0;
   localparam logic CSR_HASH_COUNT = 1'b1;

   localparam logic [16:0] BIT_COUNT_RESET  = 17'd65536;
   localparam logic [4:0]  HASH_COUNT_RESET = 5'd7;

endpackage

// ===== rtl/core/bfdh_ram.sv =====
// generic single-port-write ram with registered read
module bfdh_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bfdh_mul64.sv =====
// iterative 64x64 multiplier, low 64 bits, one 32x32 product per cycle
module bfdh_mul64 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] product
);

   logic        active_ff, active_in;
   logic [1:0]  phase_ff, phase_in;
   logic        done_ff, done_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] op_x;
   logic [31:0] op_y;

   // phase 0: lo*lo, phase 1: lo*hi, phase 2: hi*lo; cross terms land in the upper half
   assign op_x = (phase_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
   assign op_y = (phase_ff == 2'd1) ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      done_in   = 1'b0;
      a_in      = a_ff;
      b_in      = b_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      if (start) begin
         active_in = 1'b1;
         phase_in  = 2'd0;
         a_in      = a;
         b_in      = b;
      end else if (active_ff) begin
         prod_in  = op_x * op_y;
         phase_in = phase_ff + 2'd1;
         case (phase_ff)
            2'd0: begin
               acc_in = acc_ff;
            end
            2'd1: begin
               acc_in = prod_ff;
            end
            2'd2: begin
               acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            end
            2'd3: begin
               acc_in    = acc_ff + {prod_ff[31:0], 32'd0};
               active_in = 1'b0;
               done_in   = 1'b1;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= 2'd0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         done_ff   <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/core/bloom_filter_double_hash_unit.sv =====
// bloom filter with double hashing: key hashing, probe sequencer and bit store
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  request | start, busy, req_kind, req_key_word,    | taken when start & !busy
//          | req_valid_bytes, req_last               |
//  result  | rsp_valid, rsp_present, rsp_status,     | one-cycle strobe, no backpressure
//          | rsp_items_inserted, rsp_bits_set        |
//  csr     | csr_write_enable, csr_index,            | written at any edge with enable
//          | csr_write_data                          |
//
// a full key word takes 5 multiplies on the shared iterative 64x64 multiplier;
// a last word adds 3 more multiplies plus, per probe, a 64-step bit-serial modulo,
// a ram read and a check/write.
// clear sweeps the bit ram one entry a cycle; the same sweep
// runs after reset with busy high. results cannot be stalled.
module bloom_filter_double_hash_unit #(
   parameter int unsigned FILTER_BITS = bfdh_pkg::FILTER_BITS_DEFAULT,
   parameter int unsigned MAX_PROBES  = bfdh_pkg::MAX_PROBES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_key_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic        rsp_present,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_items_inserted,
   output logic [16:0] rsp_bits_set,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [16:0] csr_write_data
);

   localparam int unsigned AW = $clog2(FILTER_BITS);
   localparam int unsigned MW = $clog2(FILTER_BITS + 1);
   localparam int unsigned PW = $clog2(MAX_PROBES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLR, ST_K1, ST_K2, ST_K3, ST_K4, ST_H2,
      ST_FIN, ST_F1, ST_F2, ST_F3, ST_DIV, ST_RD, ST_CHK, ST_DONE
   } state_type;

   function automatic logic [63:0] byte_mask(input logic [3:0] vb);
      logic [63:0] m;
      m = '0;
      for (int n = 0; n < 8; n++) begin
         m[8*n +: 8] = (4'(n) < vb) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

   state_type   state_ff, state_in;
   logic [63:0] word_ff, word_in;
   logic        last_ff, last_in;
   logic        query_ff, query_in;
   logic [63:0] h1_ff, h1_in;
   logic [63:0] h2_ff, h2_in;
   logic [31:0] len_ff, len_in;
   logic [1:0]  err_ff, err_in;
   logic [31:0] ins_ff, ins_in;
   logic [MW-1:0] set_ff, set_in;
   logic        present_ff, present_in;
   logic [MW-1:0] m_ff, m_in;
   logic [PW-1:0] probes_ff, probes_in;
   logic [PW-1:0] pidx_ff, pidx_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] dv_ff, dv_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [MW-1:0] r_ff, r_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic        clr_rsp_ff, clr_rsp_in;
   logic [16:0] bit_count_ff, bit_count_in;
   logic [4:0]  hash_count_ff, hash_count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_present_ff, rsp_present_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_items_ff, rsp_items_in;
   logic [16:0] rsp_bits_ff, rsp_bits_in;

   logic        mul_start;
   logic [63:0] mul_a;
   logic [63:0] mul_b;
   logic        mul_done;
   logic [63:0] mul_p;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic          ram_wr_data;
   logic          ram_rd_data;

   logic [3:0]  vb8;
   logic [32:0] len_sum;
   logic [63:0] k_part;
   logic [63:0] t_mix;
   logic [63:0] h1_x;
   logic [63:0] h1_rot;
   logic [MW:0] rem_cat;
   logic [MW:0] rem_sub;
   logic [31:0] bc_wide;
   logic [31:0] ins_next;
   logic [16:0] bits_sat;

   bfdh_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   bfdh_ram #(
      .WIDTH (1),
      .DEPTH (FILTER_BITS)
   ) u_bits (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (r_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign vb8      = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
   assign len_sum  = {1'b0, len_ff} + 33'(vb8);
   assign k_part   = req_key_word & byte_mask(vb8);
   assign t_mix    = (h1_ff ^ {32'd0, len_ff}) ^ ((h1_ff ^ {32'd0, len_ff}) >> 33);
   assign h1_x     = h1_ff ^ mul_p;
   assign h1_rot   = {h1_x[36:0], h1_x[63:37]};
   assign rem_cat  = {r_ff, dv_ff[63]};
   assign rem_sub  = rem_cat - {1'b0, m_ff};
   assign bc_wide  = {15'd0, bit_count_ff};
   assign ins_next = (ins_ff == 32'hffffffff) ? ins_ff : ins_ff + 32'd1;
   assign bits_sat = (32'(set_ff) > 32'h1ffff) ? 17'h1ffff : 17'(set_ff);

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      last_in       = last_ff;
      query_in      = query_ff;
      h1_in         = h1_ff;
      h2_in         = h2_ff;
      len_in        = len_ff;
      err_in        = err_ff;
      ins_in        = ins_ff;
      set_in        = set_ff;
      present_in    = present_ff;
      m_in          = m_ff;
      probes_in     = probes_ff;
      pidx_in       = pidx_ff;
      v_in          = v_ff;
      dv_in         = dv_ff;
      cnt_in        = cnt_ff;
      r_in          = r_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      bit_count_in  = bit_count_ff;
      hash_count_in = hash_count_ff;
      rsp_valid_in   = 1'b0;
      rsp_present_in = rsp_present_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_items_in   = rsp_items_ff;
      rsp_bits_in    = rsp_bits_ff;
      mul_start   = 1'b0;
      mul_a       = h2_ff;
      mul_b       = bfdh_pkg::SEED_M;
      ram_wr_en   = 1'b0;
      ram_wr_addr = r_ff[AW-1:0];
      ram_wr_data = 1'b1;

      if (csr_write_enable) begin
         if (csr_index == bfdh_pkg::CSR_BIT_COUNT) begin
            bit_count_in = csr_write_data;
         end else begin
            hash_count_in = csr_write_data[4:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == bfdh_pkg::KIND_CLEAR) begin
                  state_in    = ST_CLR;
                  clr_addr_in = '0;
                  clr_rsp_in  = 1'b1;
                  ins_in      = '0;
                  set_in      = '0;
                  h1_in       = bfdh_pkg::SEED_A;
                  h2_in       = bfdh_pkg::SEED_M;
                  len_in      = '0;
                  err_in      = bfdh_pkg::STATUS_OK;
               end else if (req_kind == bfdh_pkg::KIND_INSERT ||
                            req_kind == bfdh_pkg::KIND_QUERY) begin
                  word_in  = req_key_word;
                  last_in  = req_last;
                  query_in = (req_kind == bfdh_pkg::KIND_QUERY);
                  if (err_ff == bfdh_pkg::STATUS_OK) begin
                     if (!req_last && vb8 < 4'd8) begin
                        err_in = bfdh_pkg::STATUS_SHORT;
                     end else if (len_sum[32]) begin
                        err_in = bfdh_pkg::STATUS_OVERFLOW;
                     end
                  end
                  if (err_ff == bfdh_pkg::STATUS_OK && err_in == bfdh_pkg::STATUS_OK &&
                      vb8 != 4'd0) begin
                     len_in = len_sum[31:0];
                     if (vb8 == 4'd8) begin
                        mul_start = 1'b1;
                        mul_a     = req_key_word;
                        mul_b     = bfdh_pkg::MUL_C1;
                        state_in  = ST_K1;
                     end else begin
                        // tail bytes skip the word mix on the first hash
                        h1_in     = h1_ff ^ k_part;
                        h2_in     = h2_ff ^ k_part;
                        mul_start = 1'b1;
                        mul_a     = h2_ff ^ k_part;
                        mul_b     = bfdh_pkg::SEED_M;
                        state_in  = ST_H2;
                     end
                  end else if (req_last) begin
                     if (err_in != bfdh_pkg::STATUS_OK) begin
                        rsp_valid_in   = 1'b1;
                        rsp_present_in = 1'b0;
                        rsp_status_in  = err_in;
                        rsp_items_in   = ins_ff;
                        rsp_bits_in    = bits_sat;
                        h1_in          = bfdh_pkg::SEED_A;
                        h2_in          = bfdh_pkg::SEED_M;
                        len_in         = '0;
                        err_in         = bfdh_pkg::STATUS_OK;
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
               end
            end
         end
         ST_CLR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = 1'b0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(FILTER_BITS - 1)) begin
               state_in = ST_IDLE;
               if (clr_rsp_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_present_in = 1'b0;
                  rsp_status_in  = bfdh_pkg::STATUS_OK;
                  rsp_items_in   = ins_ff;
                  rsp_bits_in    = bits_sat;
               end
            end
         end
         ST_K1: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = {mul_p[32:0], mul_p[63:33]};
               mul_b     = bfdh_pkg::MUL_C2;
               state_in  = ST_K2;
            end
         end
         ST_K2: begin
            if (mul_done) begin
               h1_in     = (h1_rot << 2) + h1_rot + bfdh_pkg::ADD_N;
               mul_start = 1'b1;
               mul_a     = word_ff;
               mul_b     = bfdh_pkg::SEED_M;
               state_in  = ST_K3;
            end
         end
         ST_K3: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = mul_p ^ (mul_p >> 47);
               mul_b     = bfdh_pkg::SEED_M;
               state_in  = ST_K4;
            end
         end
         ST_K4: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = h2_ff ^ mul_p;
               mul_b     = bfdh_pkg::SEED_M;
               state_in  = ST_H2;
            end
         end
         ST_H2: begin
            if (mul_done) begin
               h2_in    = mul_p;
               state_in = last_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_FIN: begin
            mul_start = 1'b1;
            mul_a     = t_mix;
            mul_b     = bfdh_pkg::FMIX_1;
            state_in  = ST_F1;
            if (bit_count_ff == 17'd0) begin
               m_in = MW'(1);
            end else if (bc_wide > 32'(FILTER_BITS)) begin
               m_in = MW'(FILTER_BITS);
            end else begin
               m_in = MW'(bit_count_ff);
            end
            if (32'(hash_count_ff) > 32'(MAX_PROBES)) begin
               probes_in = PW'(MAX_PROBES);
            end else begin
               probes_in = PW'(hash_count_ff);
            end
         end
         ST_F1: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = mul_p ^ (mul_p >> 33);
               mul_b     = bfdh_pkg::FMIX_2;
               state_in  = ST_F2;
            end
         end
         ST_F2: begin
            if (mul_done) begin
               h1_in     = mul_p ^ (mul_p >> 33);
               mul_start = 1'b1;
               mul_a     = h2_ff ^ (h2_ff >> 47);
               mul_b     = bfdh_pkg::SEED_M;
               state_in  = ST_F3;
            end
         end
         ST_F3: begin
            if (mul_done) begin
               h2_in      = mul_p ^ (mul_p >> 47);
               v_in       = h1_ff;
               dv_in      = h1_ff;
               r_in       = '0;
               cnt_in     = '0;
               pidx_in    = '0;
               present_in = 1'b1;
               state_in   = (probes_ff == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring remainder, one dividend bit a cycle
            r_in   = rem_cat >= {1'b0, m_ff} ? rem_sub[MW-1:0] : rem_cat[MW-1:0];
            dv_in  = {dv_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (query_ff) begin
               present_in = present_ff & ram_rd_data;
            end else if (!ram_rd_data) begin
               ram_wr_en = 1'b1;
               set_in    = set_ff + 1'b1;
            end
            pidx_in = pidx_ff + 1'b1;
            v_in    = v_ff + h2_ff;
            dv_in   = v_ff + h2_ff;
            r_in    = '0;
            cnt_in  = '0;
            state_in = (pidx_ff + 1'b1 == probes_ff) ? ST_DONE : ST_DIV;
         end
         ST_DONE: begin
            if (!query_ff) begin
               ins_in = ins_next;
            end
            rsp_valid_in   = 1'b1;
            rsp_present_in = query_ff & present_ff;
            rsp_status_in  = bfdh_pkg::STATUS_OK;
            rsp_items_in   = query_ff ? ins_ff : ins_next;
            rsp_bits_in    = bits_sat;
            h1_in          = bfdh_pkg::SEED_A;
            h2_in          = bfdh_pkg::SEED_M;
            len_in         = '0;
            err_in         = bfdh_pkg::STATUS_OK;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR;
         clr_addr_ff   <= '0;
         clr_rsp_ff    <= 1'b0;
         h1_ff         <= bfdh_pkg::SEED_A;
         h2_ff         <= bfdh_pkg::SEED_M;
         len_ff        <= '0;
         err_ff        <= bfdh_pkg::STATUS_OK;
         ins_ff        <= '0;
         set_ff        <= '0;
         bit_count_ff  <= bfdh_pkg::BIT_COUNT_RESET;
         hash_count_ff <= bfdh_pkg::HASH_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         clr_rsp_ff    <= clr_rsp_in;
         h1_ff         <= h1_in;
         h2_ff         <= h2_in;
         len_ff        <= len_in;
         err_ff        <= err_in;
         ins_ff        <= ins_in;
         set_ff        <= set_in;
         bit_count_ff  <= bit_count_in;
         hash_count_ff <= hash_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      word_ff        <= word_in;
      last_ff        <= last_in;
      query_ff       <= query_in;
      present_ff     <= present_in;
      m_ff           <= m_in;
      probes_ff      <= probes_in;
      pidx_ff        <= pidx_in;
      v_ff           <= v_in;
      dv_ff          <= dv_in;
      cnt_ff         <= cnt_in;
      r_ff           <= r_in;
      rsp_present_ff <= rsp_present_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_items_ff   <= rsp_items_in;
      rsp_bits_ff    <= rsp_bits_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_present        = rsp_present_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_items_inserted = rsp_items_ff;
   assign rsp_bits_set       = rsp_bits_ff;

endmodule
